// ===== sv/ecam_pkg.sv =====
// Package: shared types, constants and arithmetic helpers for the camera orientation block
`default_nettype none
package ecam_pkg;

  localparam int YAW_FULL    = 23040;
  localparam int YAW_QUARTER = 5760;
  localparam int PITCH_LIMIT = 5696;
  localparam int FOV_MIN     = 64;
  localparam int FOV_MAX     = 2880;
  localparam int YAW_RESET   = 17280;
  localparam int UNIT_Q14    = 16384;
  localparam int RAD_PER_UNIT = 292818;  // radians per 1/64 degree in Q30

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE      = 4'd1;
  localparam logic [15:0] SENS_RESET = 16'd6554;

  localparam logic CMD_MOVE   = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  localparam logic FN_SIN = 1'b0;
  localparam logic FN_COS = 1'b1;

  typedef logic signed [32:0] mop_t;   // multiplier operand
  typedef logic signed [65:0] prod_t;  // multiplier product
  typedef logic signed [15:0] comp_t;  // Q1.14 component

  localparam mop_t Q30_ONE = 33'sd1073741824;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCALE_X, ST_SCALE_Y, ST_PITCH, ST_YAW_RED,
    ST_ANG_LOAD, ST_QUAD, ST_XMUL, ST_X2MUL, ST_X2CAP,
    ST_HMUL, ST_HDIV, ST_HCOR, ST_HFIN, ST_SXMUL, ST_SXCAP,
    ST_PROD, ST_BASIS, ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic             command;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic             out_free;
  } ecam_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ecam_stat_t;

  // one Horner step: divisor, reciprocal and shift select
  typedef struct packed {
    logic [7:0]  d;
    logic [31:0] magic;
    logic        short_sh;  // shift 32 instead of 34
    logic        last;
  } hstep_t;

  function automatic hstep_t hstep(input logic fn, input logic [2:0] k);
    hstep_t h;
    h = '{d: 8'd0, magic: 32'd0, short_sh: 1'b0, last: 1'b0};
    if (fn == FN_SIN) begin
      case (k)
        3'd0: h = '{d: 8'd110, magic: 32'd156180628,  short_sh: 1'b0, last: 1'b0};
        3'd1: h = '{d: 8'd72,  magic: 32'd238609294,  short_sh: 1'b0, last: 1'b0};
        3'd2: h = '{d: 8'd42,  magic: 32'd409044504,  short_sh: 1'b0, last: 1'b0};
        3'd3: h = '{d: 8'd20,  magic: 32'd858993459,  short_sh: 1'b0, last: 1'b0};
        3'd4: h = '{d: 8'd6,   magic: 32'd2863311530, short_sh: 1'b0, last: 1'b1};
        default: h = '{d: 8'd6, magic: 32'd2863311530, short_sh: 1'b0, last: 1'b1};
      endcase
    end else begin
      case (k)
        3'd0: h = '{d: 8'd132, magic: 32'd130150524,  short_sh: 1'b0, last: 1'b0};
        3'd1: h = '{d: 8'd90,  magic: 32'd190887435,  short_sh: 1'b0, last: 1'b0};
        3'd2: h = '{d: 8'd56,  magic: 32'd306783378,  short_sh: 1'b0, last: 1'b0};
        3'd3: h = '{d: 8'd30,  magic: 32'd572662306,  short_sh: 1'b0, last: 1'b0};
        3'd4: h = '{d: 8'd12,  magic: 32'd1431655765, short_sh: 1'b0, last: 1'b0};
        3'd5: h = '{d: 8'd2,   magic: 32'd2147483648, short_sh: 1'b1, last: 1'b1};
        default: h = '{d: 8'd2, magic: 32'd2147483648, short_sh: 1'b1, last: 1'b1};
      endcase
    end
    return h;
  endfunction

  // Q30 product scaled back, truncated toward zero
  function automatic mop_t qtrunc(input prod_t p);
    prod_t adj;
    adj = p;
    if (p < 0) adj = p + 66'sd1073741823;
    return mop_t'(adj >>> 30);
  endfunction

  // Q30 to Q14, round half away from zero, clamp to one
  function automatic comp_t to_q14(input mop_t v);
    logic [33:0] mag;
    logic [33:0] rnd;
    logic [14:0] r;
    mag = (v < 0) ? 34'(-35'(v)) : 34'(v);
    rnd = (mag + 34'd32768) >> 16;
    r = (rnd > 34'(UNIT_Q14)) ? 15'(UNIT_Q14) : rnd[14:0];
    return (v < 0) ? -comp_t'({1'b0, r}) : comp_t'({1'b0, r});
  endfunction

endpackage
`default_nettype wire

// ===== sv/ecam_if.sv =====
// Interfaces: input, result and configuration channels
`default_nettype none
interface ecam_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  modport source (output valid, command, delta_x, delta_y, input ready);
  modport sink (input valid, command, delta_x, delta_y, output ready);
endinterface

interface ecam_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic [11:0]       field_of_view;
  modport source (output valid, front_x, front_y, front_z, right_x, right_y, right_z,
                  up_x, up_y, up_z, field_of_view, input ready);
  modport sink (input valid, front_x, front_y, front_z, right_x, right_y, right_z,
                up_x, up_y, up_z, field_of_view, output ready);
endinterface

interface ecam_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reg_index;
  logic [15:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/ecam_mul.sv =====
// Shared signed multiplier with registered product
`default_nettype none
module ecam_mul
  import ecam_pkg::*;
(
  input  wire logic  clk,
  input  wire mop_t  a,
  input  wire mop_t  b,
  output prod_t      p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

// ===== sv/ecam_seq.sv =====
// Sequencer and datapath: angle update, series sin/cos and basis rebuild
`default_nettype none
module ecam_seq
  import ecam_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ecam_req_t  req,
  input  wire logic [15:0] sens,
  input  wire logic       upd,
  input  wire prod_t      p_r,
  output mop_t            mul_a,
  output mop_t            mul_b,
  output ecam_stat_t      stat,
  output comp_t           basis [9],
  output logic [11:0]     fov
);

  seq_state_t state_r, state_nxt;

  logic signed [15:0] dx_r, dy_r;
  logic [14:0]        yaw_r;
  logic signed [13:0] pitch_r;
  logic [11:0]        fov_r;
  comp_t              basis_r [9];
  logic [16:0]        yred_r;
  logic               sel_r;      // 0 yaw, 1 pitch
  logic [14:0]        m_r;
  logic [1:0]         quad_r;
  mop_t               x_r, x2_r, acc_r, t_r, q0_r, sv_r;
  logic               fn_r;
  logic [2:0]         k_r;
  mop_t               sy_r, cy_r, sp_r, cp_r;
  mop_t               prod_r [4];
  logic [2:0]         j_r;

  hstep_t             hs;
  logic signed [17:0] scaled;
  logic signed [18:0] yaw_sum, pitch_sum;
  logic signed [13:0] pitch_new;
  logic signed [17:0] fov_sum;
  logic [11:0]        fov_new;
  logic signed [33:0] rem;
  mop_t               q_fin, cv, s_val, c_val, t_now, q0_now;
  prod_t              p_rnd;

  assign hs = hstep(fn_r, k_r);

  always_comb begin
    p_rnd   = p_r + 66'sd32768;
    scaled  = 18'(p_rnd >>> 16);
    yaw_sum = 19'(yaw_r) + 19'(scaled) + 19'(YAW_FULL * 2);
    pitch_sum = 19'(pitch_r) + 19'(scaled);
    if (pitch_sum > 19'(PITCH_LIMIT)) pitch_new = 14'(PITCH_LIMIT);
    else if (pitch_sum < -19'(PITCH_LIMIT)) pitch_new = -14'(PITCH_LIMIT);
    else pitch_new = pitch_sum[13:0];
    fov_sum = 18'(fov_r) - 18'(req.delta_y);
    if (fov_sum < 18'(FOV_MIN)) fov_new = 12'(FOV_MIN);
    else if (fov_sum > 18'(FOV_MAX)) fov_new = 12'(FOV_MAX);
    else fov_new = fov_sum[11:0];
    t_now  = qtrunc(p_r);
    q0_now = hs.short_sh ? mop_t'(p_r >>> 32) : mop_t'(p_r >>> 34);
    rem    = 34'(t_r) - 34'(p_r[32:0]);
    q_fin  = (rem >= 34'(hs.d)) ? q0_r + 33'sd1 : q0_r;
    cv     = Q30_ONE - q_fin;
    case (quad_r)
      2'd0: begin s_val = sv_r;  c_val = cv;    end
      2'd1: begin s_val = cv;    c_val = -sv_r; end
      2'd2: begin s_val = -sv_r; c_val = -cv;   end
      default: begin s_val = -cv; c_val = sv_r; end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req.start) state_nxt = (req.command == CMD_SCROLL) ? ST_DONE : ST_SCALE_X;
      end
      ST_SCALE_X: state_nxt = ST_SCALE_Y;
      ST_SCALE_Y: state_nxt = ST_PITCH;
      ST_PITCH:   state_nxt = ST_YAW_RED;
      ST_YAW_RED: begin
        if (yred_r < 17'(YAW_FULL)) state_nxt = upd ? ST_ANG_LOAD : ST_DONE;
      end
      ST_ANG_LOAD: state_nxt = ST_QUAD;
      ST_QUAD: begin
        if (m_r < 15'(YAW_QUARTER)) state_nxt = ST_XMUL;
      end
      ST_XMUL:  state_nxt = ST_X2MUL;
      ST_X2MUL: state_nxt = ST_X2CAP;
      ST_X2CAP: state_nxt = ST_HMUL;
      ST_HMUL:  state_nxt = ST_HDIV;
      ST_HDIV:  state_nxt = ST_HCOR;
      ST_HCOR:  state_nxt = ST_HFIN;
      ST_HFIN: begin
        if (!hs.last) state_nxt = ST_HMUL;
        else if (fn_r == FN_SIN) state_nxt = ST_SXMUL;
        else if (!sel_r) state_nxt = ST_ANG_LOAD;
        else state_nxt = ST_PROD;
      end
      ST_SXMUL: state_nxt = ST_SXCAP;
      ST_SXCAP: state_nxt = ST_HMUL;
      ST_PROD: begin
        if (j_r == 3'd4) state_nxt = ST_BASIS;
      end
      ST_BASIS: state_nxt = ST_DONE;
      ST_DONE: begin
        if (req.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operands and status
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SCALE_X: begin mul_a = 33'(dx_r); mul_b = 33'({1'b0, sens}); end
      ST_SCALE_Y: begin mul_a = 33'(dy_r); mul_b = 33'({1'b0, sens}); end
      ST_XMUL:    begin mul_a = 33'({1'b0, m_r}); mul_b = 33'(RAD_PER_UNIT); end
      ST_X2MUL:   begin mul_a = p_r[32:0]; mul_b = p_r[32:0]; end
      ST_HMUL:    begin mul_a = x2_r; mul_b = acc_r; end
      ST_HDIV:    begin mul_a = t_now; mul_b = 33'({1'b0, hs.magic}); end
      ST_HCOR:    begin mul_a = q0_now; mul_b = 33'({1'b0, hs.d}); end
      ST_SXMUL:   begin mul_a = x_r; mul_b = acc_r; end
      ST_PROD: begin
        case (j_r[1:0])
          2'd0: begin mul_a = cy_r; mul_b = cp_r; end
          2'd1: begin mul_a = sy_r; mul_b = cp_r; end
          2'd2: begin mul_a = cy_r; mul_b = sp_r; end
          default: begin mul_a = sy_r; mul_b = sp_r; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    stat.idle = (state_r == ST_IDLE);
    stat.done = (state_r == ST_DONE) && req.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      yaw_r   <= 15'(YAW_RESET);
      pitch_r <= '0;
      fov_r   <= 12'(FOV_MAX);
      for (int i = 0; i < 9; i++) basis_r[i] <= '0;
      basis_r[2] <= -comp_t'(UNIT_Q14);
      basis_r[3] <= comp_t'(UNIT_Q14);
      basis_r[7] <= comp_t'(UNIT_Q14);
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            dx_r <= req.delta_x;
            dy_r <= req.delta_y;
            if (req.command == CMD_SCROLL) fov_r <= fov_new;
          end
        end
        ST_SCALE_Y: yred_r <= yaw_sum[16:0];
        ST_PITCH:   pitch_r <= pitch_new;
        ST_YAW_RED: begin
          if (yred_r >= 17'(YAW_FULL)) yred_r <= yred_r - 17'(YAW_FULL);
          else begin
            yaw_r <= yred_r[14:0];
            sel_r <= 1'b0;
          end
        end
        ST_ANG_LOAD: begin
          quad_r <= '0;
          if (!sel_r) m_r <= yaw_r;
          else if (pitch_r < 0) m_r <= 15'(16'(pitch_r) + 16'(YAW_FULL));
          else m_r <= 15'(pitch_r);
        end
        ST_QUAD: begin
          if (m_r >= 15'(YAW_QUARTER)) begin
            m_r    <= m_r - 15'(YAW_QUARTER);
            quad_r <= quad_r + 2'd1;
          end
        end
        ST_X2MUL: x_r <= p_r[32:0];
        ST_X2CAP: begin
          x2_r  <= mop_t'(p_r >>> 30);
          acc_r <= Q30_ONE;
          k_r   <= '0;
          fn_r  <= FN_SIN;
        end
        ST_HDIV: t_r  <= t_now;
        ST_HCOR: q0_r <= q0_now;
        ST_HFIN: begin
          acc_r <= cv;
          k_r   <= k_r + 3'd1;
          if (hs.last && fn_r == FN_COS) begin
            if (!sel_r) begin
              sy_r  <= s_val;
              cy_r  <= c_val;
              sel_r <= 1'b1;
            end else begin
              sp_r <= s_val;
              cp_r <= c_val;
              j_r  <= '0;
            end
          end
        end
        ST_SXCAP: begin
          sv_r  <= t_now;
          acc_r <= Q30_ONE;
          k_r   <= '0;
          fn_r  <= FN_COS;
        end
        ST_PROD: begin
          if (j_r != 3'd0) prod_r[2'(j_r - 3'd1)] <= t_now;
          j_r <= j_r + 3'd1;
        end
        ST_BASIS: begin
          basis_r[0] <= to_q14(prod_r[0]);
          basis_r[1] <= to_q14(sp_r);
          basis_r[2] <= to_q14(prod_r[1]);
          basis_r[3] <= to_q14(-sy_r);
          basis_r[4] <= '0;
          basis_r[5] <= to_q14(cy_r);
          basis_r[6] <= to_q14(-prod_r[2]);
          basis_r[7] <= to_q14(cp_r);
          basis_r[8] <= to_q14(-prod_r[3]);
        end
        default: ;
      endcase
    end
  end

  assign basis = basis_r;
  assign fov   = fov_r;

endmodule
`default_nettype wire

// ===== sv/euler_camera_orientation_top.sv =====
// Euler fly-camera orientation: one shared multiplier walking the sin/cos series.
// Scroll events only update the field of view; move events scale the deltas and update
// yaw and pitch, and with updating on also rebuild the basis through the one 33x33 multiplier
// that takes every series term, division reciprocal and basis product in turn.
// Events are taken one at a time, only while idle; a new event is taken while a result waits.
// Reset (rst_n low, synchronous): yaw 270 deg, pitch 0, fov 45 deg, default basis.
`default_nettype none
module euler_camera_orientation_top
  import ecam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ecam_in_if.sink   in_ch,
  ecam_out_if.source out_ch,
  ecam_cfg_if.sink  cfg_ch
);

  logic [15:0] sens_r;
  logic        upd_r;
  logic        out_valid_r;
  comp_t       out_basis_r [9];
  logic [11:0] out_fov_r;

  ecam_req_t  req;
  ecam_stat_t stat;
  mop_t       mul_a, mul_b;
  prod_t      p_r;
  comp_t      basis [9];
  logic [11:0] fov;

  assign in_ch.ready  = stat.idle;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    req.start    = in_ch.valid && in_ch.ready;
    req.command  = in_ch.command;
    req.delta_x  = in_ch.delta_x;
    req.delta_y  = in_ch.delta_y;
    req.out_free = !out_valid_r || out_ch.ready;
  end

  ecam_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r));

  ecam_seq u_seq (
    .clk(clk), .rst_n(rst_n), .req(req), .sens(sens_r), .upd(upd_r),
    .p_r(p_r), .mul_a(mul_a), .mul_b(mul_b), .stat(stat),
    .basis(basis), .fov(fov)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r      <= SENS_RESET;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.reg_index == CFG_SENSITIVITY) sens_r <= cfg_ch.wdata;
        else if (cfg_ch.reg_index == CFG_UPDATE) upd_r <= cfg_ch.wdata[0];
      end
      if (stat.done) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_basis_r <= basis;
      out_fov_r   <= fov;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.front_x       = out_basis_r[0];
  assign out_ch.front_y       = out_basis_r[1];
  assign out_ch.front_z       = out_basis_r[2];
  assign out_ch.right_x       = out_basis_r[3];
  assign out_ch.right_y       = out_basis_r[4];
  assign out_ch.right_z       = out_basis_r[5];
  assign out_ch.up_x          = out_basis_r[6];
  assign out_ch.up_y          = out_basis_r[7];
  assign out_ch.up_z          = out_basis_r[8];
  assign out_ch.field_of_view = out_fov_r;

endmodule
`default_nettype wire

// ===== sv/ecam_checker.sv =====
// Port-level checker for the camera orientation block, bound to the top level
`default_nettype none
module ecam_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic signed [15:0] right_y,
  input wire logic [11:0] field_of_view
);

  // a finished result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // block goes busy right after taking an event
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_right_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> right_y == 16'sd0)
    else $error("right_y nonzero");

  a_fov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> field_of_view >= 12'd64 && field_of_view <= 12'd2880)
    else $error("fov out of range");

endmodule

bind euler_camera_orientation_top ecam_checker u_ecam_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .right_y(out_ch.right_y), .field_of_view(out_ch.field_of_view)
);
`default_nettype wire
